### rtl/assert_macros.svh
// assertion macros for the rtl modules, included by astm_span_gen
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/astm_pkg.sv
// types, constants and address functions of the span texture mapper
package astm_pkg;

	localparam int TEX_ADDR_BITS = 18;
	localparam int LIGHT_LEVELS  = 32;
	localparam int MAX_SPAN      = 64;

	localparam int TEX_AW       = TEX_ADDR_BITS;
	localparam int TEX_DEPTH    = 1 << TEX_AW;
	localparam int LIGHT_W      = (LIGHT_LEVELS > 1) ? $clog2(LIGHT_LEVELS) : 1;
	localparam int LIGHT_DEPTH  = LIGHT_LEVELS * 256;
	localparam int CM_AW        = LIGHT_W + 8;
	localparam int CNT_W        = $clog2(MAX_SPAN + 1);
	localparam int TA_FULL_W    = 18;

	localparam logic [1:0] MODE_TEX  = 2'd0;
	localparam logic [1:0] MODE_CMAP = 2'd1;
	localparam logic [1:0] MODE_SPAN = 2'd2;

	localparam logic [1:0] CFG_SIZE       = 2'd0;
	localparam logic [1:0] CFG_LOW_DETAIL = 2'd1;
	localparam logic [1:0] CFG_LOW_PREC   = 2'd2;

	localparam logic [1:0] SIZE_64  = 2'd0;
	localparam logic [1:0] SIZE_128 = 2'd1;
	localparam logic [1:0] SIZE_256 = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [17:0] load_address;
		logic [7:0]  load_data;
		logic [31:0] u_start;
		logic [31:0] v_start;
		logic [31:0] u_step;
		logic [31:0] v_step;
		logic [10:0] start_column;
		logic [6:0]  pixel_count;
		logic [9:0]  screen_row;
		logic [4:0]  light_level;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  color;
		logic [11:0] column;
		logic [9:0]  row;
		logic        double_width;
		logic        last;
	} pix_t;

	typedef struct packed {
		logic [1:0] texture_size_code;
		logic       low_detail;
		logic       low_precision;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic               load_ok;
		logic [TEX_AW-1:0]  tex_addr;
		logic [CM_AW-1:0]   cm_addr;
		logic [7:0]         load_data;
		logic [LIGHT_W-1:0] light;
		logic [11:0]        column;
		logic [9:0]         row;
		logic               double_width;
		logic               last;
	} item_t;

	function automatic logic [31:0] pack_pos(input logic [31:0] u, input logic [31:0] v);
		return {v[21:6], u[21:6]};
	endfunction

	function automatic logic [TA_FULL_W-1:0] texel_addr(input logic [31:0] u,
		input logic [31:0] v, input logic [31:0] pos, input logic [1:0] code,
		input logic packed_path);
		logic [TA_FULL_W-1:0] ta;
		if (packed_path) begin
			ta = {6'd0, pos[15:10], pos[31:26]};
		end else begin
			case (code)
				SIZE_64:  ta = {6'd0, u[31:26], v[31:26]};
				SIZE_128: ta = {4'd0, u[31:25], v[31:25]};
				SIZE_256: ta = {2'd0, u[31:24], v[31:24]};
				default:  ta = {u[31:23], v[31:23]};
			endcase
		end
		return ta;
	endfunction

endpackage

### rtl/astm_ram.sv
// generic single-port ram with registered read
module astm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/astm_span_gen.sv
// command register and per-pixel coordinate stepping
`include "assert_macros.svh"
module astm_span_gen (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  astm_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  astm_pkg::cmd_t cmd,
	output logic           valid_s1,
	output astm_pkg::item_t item_s1
);

	import astm_pkg::*;

	logic                 busy_q;
	logic [1:0]           kind_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [31:0]          u_q;
	logic [31:0]          v_q;
	logic [31:0]          pos_q;
	logic [31:0]          us_q;
	logic [31:0]          vs_q;
	logic [31:0]          ps_q;
	logic [11:0]          col_q;
	logic [9:0]           row_q;
	logic [LIGHT_W-1:0]   light_q;
	logic [17:0]          laddr_q;
	logic [7:0]           ldata_q;

	logic                 take;
	logic                 accept;
	logic                 emit;
	logic                 packed_path;
	logic [CNT_W-1:0]     cnt_sat;
	logic [LIGHT_W-1:0]   light_sat;
	logic [11:0]          col_step;
	logic [TA_FULL_W-1:0] ta_full;
	logic                 span_start;
	item_t                item;

	assign take        = !busy_q || (cnt_q == CNT_W'(1));
	assign cmd_stall   = !(advance && take);
	assign accept      = cmd_valid && !cmd_stall;
	assign emit        = busy_q && advance;
	assign packed_path = cfg.low_precision && (cfg.texture_size_code == SIZE_64)
		&& !cfg.low_detail;
	assign col_step    = cfg.low_detail ? 12'd2 : 12'd1;
	assign span_start  = (cmd.mode == MODE_SPAN) && (cmd.pixel_count != 7'd0);

	always_comb begin
		if (32'(cmd.pixel_count) > MAX_SPAN) begin
			cnt_sat = CNT_W'(MAX_SPAN);
		end else begin
			cnt_sat = CNT_W'(cmd.pixel_count);
		end
		if (32'(cmd.light_level) >= LIGHT_LEVELS) begin
			light_sat = LIGHT_W'(LIGHT_LEVELS - 1);
		end else begin
			light_sat = LIGHT_W'(cmd.light_level);
		end
	end

	always_comb begin
		ta_full           = texel_addr(u_q, v_q, pos_q, cfg.texture_size_code, packed_path);
		item.kind         = kind_q;
		item.tex_addr     = (kind_q == MODE_TEX) ? laddr_q[TEX_AW-1:0] : ta_full[TEX_AW-1:0];
		item.cm_addr      = laddr_q[CM_AW-1:0];
		item.load_data    = ldata_q;
		item.light        = light_q;
		item.column       = col_q;
		item.row          = row_q;
		item.double_width = cfg.low_detail;
		item.last         = (cnt_q == CNT_W'(1));
		case (kind_q)
			MODE_TEX:  item.load_ok = 32'(laddr_q) < TEX_DEPTH;
			MODE_CMAP: item.load_ok = 32'(laddr_q) < LIGHT_DEPTH;
			default:   item.load_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			kind_q   <= MODE_TEX;
			cnt_q    <= '0;
			u_q      <= '0;
			v_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= busy_q;
			end
			if (accept) begin
				case (cmd.mode)
					MODE_TEX, MODE_CMAP: begin
						busy_q <= 1'b1;
						kind_q <= cmd.mode;
						cnt_q  <= CNT_W'(1);
					end
					MODE_SPAN: begin
						busy_q <= span_start;
						kind_q <= MODE_SPAN;
						if (span_start) begin
							cnt_q <= cnt_sat;
							u_q   <= cmd.u_start;
							v_q   <= cmd.v_start;
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end else if (emit) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				busy_q <= (cnt_q != CNT_W'(1));
				if (kind_q == MODE_SPAN) begin
					u_q <= u_q + us_q;
					v_q <= v_q + vs_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1 <= item;
		end
		if (accept) begin
			laddr_q <= cmd.load_address;
			ldata_q <= cmd.load_data;
			if (span_start) begin
				pos_q   <= pack_pos(cmd.u_start, cmd.v_start);
				us_q    <= cmd.u_step;
				vs_q    <= cmd.v_step;
				ps_q    <= pack_pos(cmd.u_step, cmd.v_step);
				col_q   <= {1'b0, cmd.start_column} << cfg.low_detail;
				row_q   <= cmd.screen_row;
				light_q <= light_sat;
			end
		end else if (emit) begin
			pos_q <= pos_q + ps_q;
			col_q <= col_q + col_step;
		end
	end

	`ASSERT_NEVER(a_busy_has_count, clk, arst_n, busy_q && (cnt_q == '0))
	`ASSERT_NEVER(a_count_bounded, clk, arst_n, 32'(cnt_q) > MAX_SPAN)
	`ASSERT_PROP(a_span_starts, clk, arst_n, accept && span_start |=> busy_q)
	`ASSERT_PROP(a_freeze_holds, clk, arst_n, !advance |=> $stable(valid_s1))

endmodule

### rtl/affine_span_texture_mapper.sv
// top level: span texture mapper with texture and colormap memories
//
// channel   dir  handshake            payload
// cmd       in   cmd_valid/cmd_stall  astm_pkg::cmd_t (load or span request)
// pix       out  pix_valid/pix_stall  astm_pkg::pix_t (one shaded pixel)
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a span occupies the stepping register until its pixels (at most 64) are stepped, one pixel per cycle unless stalled;
// a load request occupies it for a single step; the next request is taken in the last step
// pixels leave through the item register, then the texel read and colormap read registers
// reset clears control and the u and v coordinates; memories hold nothing until loaded
// a stall on pix with a pixel waiting freezes the whole pipeline, memory read registers included
module affine_span_texture_mapper (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  astm_pkg::cmd_t cmd,
	output logic           pix_valid,
	input  logic           pix_stall,
	output astm_pkg::pix_t pix,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [1:0]     cfg_data
);

	import astm_pkg::*;

	cfg_t             cfg_q;
	logic             advance;
	logic             valid_s1;
	item_t            item_s1;
	logic             valid_s2;
	item_t            item_s2;
	logic             valid_s3;
	logic [11:0]      column_s3;
	logic [9:0]       row_s3;
	logic             dw_s3;
	logic             last_s3;
	logic [7:0]       texel;
	logic [7:0]       shade;
	logic             tex_we;
	logic             cm_we;
	logic [CM_AW-1:0] cm_addr;

	assign cfg_ready = 1'b1;
	assign advance   = !valid_s3 || !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SIZE:       cfg_q.texture_size_code <= cfg_data;
				CFG_LOW_DETAIL: cfg_q.low_detail        <= cfg_data[0];
				CFG_LOW_PREC:   cfg_q.low_precision     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	astm_span_gen u_span_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	assign tex_we = valid_s1 && (item_s1.kind == MODE_TEX) && item_s1.load_ok;

	astm_ram #(
		.WIDTH (8),
		.DEPTH (TEX_DEPTH)
	) u_tex_ram (
		.clk   (clk),
		.en    (advance),
		.we    (tex_we),
		.addr  (item_s1.tex_addr),
		.wdata (item_s1.load_data),
		.rdata (texel)
	);

	assign cm_we   = valid_s2 && (item_s2.kind == MODE_CMAP) && item_s2.load_ok;
	assign cm_addr = (item_s2.kind == MODE_CMAP) ? item_s2.cm_addr : {item_s2.light, texel};

	astm_ram #(
		.WIDTH (8),
		.DEPTH (LIGHT_DEPTH)
	) u_cmap_ram (
		.clk   (clk),
		.en    (advance),
		.we    (cm_we),
		.addr  (cm_addr),
		.wdata (item_s2.load_data),
		.rdata (shade)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && (item_s2.kind == MODE_SPAN);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s2   <= item_s1;
			column_s3 <= item_s2.column;
			row_s3    <= item_s2.row;
			dw_s3     <= item_s2.double_width;
			last_s3   <= item_s2.last;
		end
	end

	assign pix_valid        = valid_s3;
	assign pix.color        = shade;
	assign pix.column       = column_s3;
	assign pix.row          = row_s3;
	assign pix.double_width = dw_s3;
	assign pix.last         = last_s3;

endmodule

### dv/affine_span_texture_mapper_tb.sv
// self-checking testbench for affine_span_texture_mapper: table-driven and random requests
`timescale 1ns / 100ps

module affine_span_texture_mapper_tb;
	import astm_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] SIZE_512  = 2'd3;
	localparam int STUCK_LIMIT       = 2000;
	localparam int RANDOM_REQUESTS   = 460;
	localparam int DRAIN_CYCLES      = 10;

	localparam cfg_t SET_PLAIN       = '{SIZE_64, 1'b0, 1'b0};
	localparam cfg_t SET_BIG         = '{SIZE_512, 1'b0, 1'b0};
	localparam cfg_t SET_128         = '{SIZE_128, 1'b0, 1'b0};
	localparam cfg_t SET_256         = '{SIZE_256, 1'b0, 1'b0};
	localparam cfg_t SET_LOWDET      = '{SIZE_64, 1'b1, 1'b0};
	localparam cfg_t SET_LOWDET_PREC = '{SIZE_64, 1'b1, 1'b1};
	localparam cfg_t SET_PREC_128    = '{SIZE_128, 1'b0, 1'b1};
	localparam cfg_t SET_PACKED      = '{SIZE_64, 1'b0, 1'b1};
	localparam pix_t NO_PIX          = '0;

	typedef logic [TEX_AW-1:0] addr_q_t[$];
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_e;
	typedef struct {
		cfg_t setting;
		cmd_t request;
		bit   typed;
		pix_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	cmd_t       cmd       = '0;
	logic       pix_valid;
	logic       pix_stall = 1'b0;
	pix_t       pix;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [1:0] cfg_data  = '0;

	logic [7:0]  tex_mem [logic [TEX_AW-1:0]];
	logic [7:0]  cmap_mem [logic [CM_AW-1:0]];
	cfg_t        cur_cfg = SET_PLAIN;
	pix_t        pending_pixels[$];

	int          mismatches  = 0;
	int          items_taken = 0;
	int          burst_left  = 0;
	int          stuck_cycles = 0;
	stall_mode_e stall_mode  = STALL_NONE;
	int          stall_cyc   = 0;
	int          run_left    = 0;
	bit          run_stalled = 1'b0;

	logic [31:0] u_pool [4];
	logic [31:0] v_pool [4];
	logic [4:0]  light_pool [4];
	logic [7:0]  data_pool [8];

	dir_row_t    rows[$];
	cmd_t        req;
	logic [31:0] us;
	logic [31:0] vs;
	int          roll;
	int          next_cfg_at;
	int          phase;

	affine_span_texture_mapper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] pack16(input logic [31:0] u, input logic [31:0] v);
		return ((v << 10) & 32'hFFFF_0000) | ((u >> 6) & 32'h0000_FFFF);
	endfunction

	// texel addresses a span reads, one per pixel, under the current setting
	function automatic addr_q_t span_texel_addrs(input cmd_t c);
		addr_q_t     q;
		logic [31:0] u;
		logic [31:0] v;
		logic [31:0] pos;
		logic [31:0] pstep;
		logic [31:0] w;
		int          k;
		int          n;
		bit          packed_path;
		u = c.u_start;
		v = c.v_start;
		pos = pack16(c.u_start, c.v_start);
		pstep = pack16(c.u_step, c.v_step);
		k = 6 + cur_cfg.texture_size_code;
		packed_path = cur_cfg.low_precision && cur_cfg.texture_size_code == SIZE_64
			&& !cur_cfg.low_detail;
		n = (c.pixel_count > MAX_SPAN) ? MAX_SPAN : c.pixel_count;
		for (int i = 0; i < n; i++) begin
			if (packed_path) begin
				w = (pos >> 26) | ((pos >> 4) & 32'h0000_0FC0);
			end else begin
				w = ((u >> (32 - k)) << k) | (v >> (32 - k));
			end
			q.push_back(w[TEX_AW-1:0]);
			u = u + c.u_step;
			v = v + c.v_step;
			pos = pos + pstep;
		end
		return q;
	endfunction

	function automatic logic [CM_AW-1:0] shade_index(input cmd_t c, input logic [7:0] texel);
		int lvl;
		lvl = (c.light_level >= LIGHT_LEVELS) ? LIGHT_LEVELS - 1 : c.light_level;
		return CM_AW'(lvl * 256 + texel);
	endfunction

	// updates the memory image and works out the pixels of one accepted request
	function automatic void render_request(input cmd_t c, input bit emit);
		addr_q_t     ta;
		pix_t        p;
		logic [11:0] col;
		case (c.mode)
			MODE_TEX: begin
				tex_mem[c.load_address] = c.load_data;
			end
			MODE_CMAP: begin
				if (c.load_address < LIGHT_DEPTH)
					cmap_mem[c.load_address[CM_AW-1:0]] = c.load_data;
			end
			MODE_SPAN: begin
				ta = span_texel_addrs(c);
				col = {1'b0, c.start_column} << cur_cfg.low_detail;
				foreach (ta[i]) begin
					p.color = cmap_mem[shade_index(c, tex_mem[ta[i]])];
					p.column = col;
					p.row = c.screen_row;
					p.double_width = cur_cfg.low_detail;
					p.last = (i == ta.size() - 1);
					if (emit)
						pending_pixels.push_back(p);
					col = col + (cur_cfg.low_detail ? 12'd2 : 12'd1);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_t mk_load(input logic [1:0] m, input logic [17:0] a,
		input logic [7:0] d);
		cmd_t c;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		c.mode = m;
		c.load_address = a;
		c.load_data = d;
		return c;
	endfunction

	function automatic cmd_t mk_span(input logic [31:0] u, input logic [31:0] v,
		input logic [31:0] u_inc, input logic [31:0] v_inc, input logic [10:0] col,
		input logic [6:0] cnt, input logic [9:0] scr_row, input logic [4:0] light);
		cmd_t c;
		c.mode = MODE_SPAN;
		c.load_address = 18'($urandom);
		c.load_data = 8'($urandom);
		c.u_start = u;
		c.v_start = v;
		c.u_step = u_inc;
		c.v_step = v_inc;
		c.start_column = col;
		c.pixel_count = cnt;
		c.screen_row = scr_row;
		c.light_level = light;
		return c;
	endfunction

	function automatic cmd_t mk_other();
		cmd_t c;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		c.mode = MODE_NONE;
		return c;
	endfunction

	function automatic logic [7:0] pick_byte();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : data_pool[$urandom_range(0, 7)];
	endfunction

	function automatic void report(input string what, input int unsigned want,
		input int unsigned got);
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		mismatches++;
	endfunction

	task automatic send_cmd(input cmd_t c, input bit emit);
		if (burst_left == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		render_request(c, emit);
		if (c.mode != MODE_NONE)
			items_taken++;
		burst_left--;
		@(negedge clk);
	endtask

	// loads whatever texels and shades the span would read that are not yet written, then sends the span
	task automatic draw_span(input cmd_t c);
		addr_q_t          ta;
		logic [CM_AW-1:0] ci;
		ta = span_texel_addrs(c);
		foreach (ta[i])
			if (!tex_mem.exists(ta[i]))
				send_cmd(mk_load(MODE_TEX, ta[i], pick_byte()), 1'b1);
		foreach (ta[i]) begin
			ci = shade_index(c, tex_mem[ta[i]]);
			if (!cmap_mem.exists(ci))
				send_cmd(mk_load(MODE_CMAP, 18'(ci), 8'($urandom)), 1'b1);
		end
		send_cmd(c, 1'b1);
	endtask

	task automatic set_config(input cfg_t n);
		logic [1:0] idx [3];
		logic [1:0] val [3];
		idx = '{CFG_SIZE, CFG_LOW_DETAIL, CFG_LOW_PREC};
		val = '{n.texture_size_code, {1'b0, n.low_detail}, {1'b0, n.low_precision}};
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		for (int r = 0; r < 3; r++) begin
			cfg_index <= idx[r];
			cfg_data <= val[r];
			do @(posedge clk); while (!cfg_ready);
			case (idx[r])
				CFG_SIZE:       cur_cfg.texture_size_code = val[r];
				CFG_LOW_DETAIL: cur_cfg.low_detail = val[r][0];
				default:        cur_cfg.low_precision = val[r][0];
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_cyc == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 3));
			stall_cyc = $urandom_range(50, 300);
		end
		stall_cyc--;
		case (stall_mode)
			STALL_NONE:  pix_stall <= 1'b0;
			STALL_LIGHT: pix_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: pix_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					run_stalled = !run_stalled;
					run_left = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 20);
				end
				run_left--;
				pix_stall <= run_stalled;
			end
		endcase
	end

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && pix_valid && !pix_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: pixel mismatch, expected none, actual %p", $time, pix);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pix.color !== want.color)
					report("color", want.color, pix.color);
				if (pix.column !== want.column)
					report("column", want.column, pix.column);
				if (pix.row !== want.row)
					report("row", want.row, pix.row);
				if (pix.double_width !== want.double_width)
					report("double_width", want.double_width, pix.double_width);
				if (pix.last !== want.last)
					report("last", want.last, pix.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall) || (cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
			$display("affine_span_texture_mapper_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_config(SET_PLAIN);

		rows.push_back('{SET_PLAIN, mk_load(MODE_TEX, 18'h00000, 8'h5A), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_load(MODE_TEX, 18'h3FFFF, 8'hFF), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_load(MODE_TEX, 18'h00FFF, 8'hFF), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_load(MODE_CMAP, 18'h0005A, 8'h11), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_load(MODE_CMAP, 18'h01FFF, 8'hEE), 1'b0, NO_PIX});
		// writes past the colormap are dropped
		rows.push_back('{SET_PLAIN, mk_load(MODE_CMAP, 18'h02000, 8'h77), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_load(MODE_CMAP, 18'h3FFFF, 8'h00), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_other(), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_span('0, '0, '0, '0, 11'd0, 7'd1, 10'd0, 5'd0),
			1'b1, pix_t'{8'h11, 12'd0, 10'd0, 1'b0, 1'b1}});
		rows.push_back('{SET_PLAIN, mk_span('1, '1, '0, '0, 11'd2047, 7'd1, 10'd1023, 5'd31),
			1'b1, pix_t'{8'hEE, 12'd2047, 10'd1023, 1'b0, 1'b1}});
		rows.push_back('{SET_PLAIN, mk_span($urandom, $urandom, $urandom, $urandom,
			11'($urandom), 7'd0, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		// count above the limit is cut to a full span
		rows.push_back('{SET_PLAIN, mk_span('0, '0, '0, '0, 11'd100, 7'd127, 10'd9, 5'd0),
			1'b0, NO_PIX});
		rows.push_back('{SET_BIG, mk_span('1, '1, '0, '0, 11'd5, 7'd1, 10'd7, 5'd31),
			1'b1, pix_t'{8'hEE, 12'd5, 10'd7, 1'b0, 1'b1}});
		rows.push_back('{SET_128, mk_span($urandom, $urandom, 32'h0200_0000, '0,
			11'($urandom), 7'd16, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		rows.push_back('{SET_256, mk_span($urandom, $urandom, '0, 32'h0100_0000,
			11'($urandom), 7'd8, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		// doubled columns wrap past 4095
		rows.push_back('{SET_LOWDET, mk_span('0, '0, '0, '0, 11'd2047, 7'd2, 10'd3, 5'd0),
			1'b0, NO_PIX});
		rows.push_back('{SET_LOWDET_PREC, mk_span($urandom, $urandom, $urandom, $urandom,
			11'($urandom), 7'd4, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		rows.push_back('{SET_PREC_128, mk_span($urandom, $urandom, $urandom, $urandom,
			11'($urandom), 7'd4, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		// packed path: u half carries into v half
		rows.push_back('{SET_PACKED, mk_span(32'h003F_FFC0, 32'h0000_FFC0, 32'h0000_0040, '0,
			11'd12, 7'd4, 10'd20, 5'd2), 1'b0, NO_PIX});
		rows.push_back('{SET_PACKED, mk_span($urandom, $urandom, '1, '1,
			11'($urandom), 7'd8, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});
		rows.push_back('{SET_PLAIN, mk_span($urandom, $urandom, $urandom, $urandom,
			11'($urandom), 7'd64, 10'($urandom), 5'($urandom)), 1'b0, NO_PIX});

		foreach (rows[i]) begin
			if (rows[i].setting != cur_cfg)
				set_config(rows[i].setting);
			if (rows[i].typed) begin
				pending_pixels.push_back(rows[i].want);
				send_cmd(rows[i].request, 1'b0);
			end else if (rows[i].request.mode == MODE_SPAN) begin
				draw_span(rows[i].request);
			end else begin
				send_cmd(rows[i].request, 1'b1);
			end
		end

		next_cfg_at = 0;
		phase = 0;
		while (items_taken < RANDOM_REQUESTS) begin
			if (items_taken >= next_cfg_at) begin
				case (phase)
					0: set_config('{SIZE_512, 1'b1, 1'b1});
					1: set_config(SET_PACKED);
					2: set_config('{SIZE_256, 1'b1, 1'b0});
					3: set_config(SET_PLAIN);
					default: begin
						if ($urandom_range(0, 2) == 0)
							set_config(SET_PACKED);
						else
							set_config(cfg_t'($urandom));
					end
				endcase
				phase++;
				next_cfg_at = items_taken + $urandom_range(40, 70);
				foreach (u_pool[i]) begin
					u_pool[i] = $urandom;
					v_pool[i] = $urandom;
					light_pool[i] = 5'($urandom);
				end
				foreach (data_pool[i])
					data_pool[i] = 8'($urandom);
			end
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				us = $urandom >> $urandom_range(10, 30);
				vs = $urandom >> $urandom_range(10, 30);
				if ($urandom_range(0, 1))
					us = -us;
				if ($urandom_range(0, 1))
					vs = -vs;
				req = mk_span((u_pool[$urandom_range(0, 3)] & 32'hFFBF_0000)
					| ($urandom & 32'h0040_FFFF),
					(v_pool[$urandom_range(0, 3)] & 32'hFFBF_0000)
					| ($urandom & 32'h0040_FFFF),
					us, vs, 11'($urandom), 7'($urandom_range(1, 63)), 10'($urandom),
					light_pool[$urandom_range(0, 3)]);
				roll = $urandom_range(0, 99);
				if (roll < 4)
					req.pixel_count = 7'd0;
				else if (roll < 10)
					req.pixel_count = 7'($urandom_range(65, 127));
				else if (roll < 25)
					req.pixel_count = 7'd64;
				draw_span(req);
			end else if (roll < 88) begin
				draw_span(mk_span($urandom, $urandom, $urandom, $urandom, 11'($urandom),
					7'($urandom_range(0, 6)), 10'($urandom), 5'($urandom)));
			end else if (roll < 93) begin
				send_cmd(mk_load(MODE_TEX, 18'($urandom), pick_byte()), 1'b1);
			end else if (roll < 97) begin
				send_cmd(mk_load(MODE_CMAP, ($urandom_range(0, 3) == 0) ? 18'($urandom)
					: 18'($urandom_range(0, LIGHT_DEPTH - 1)), 8'($urandom)), 1'b1);
			end else begin
				send_cmd(mk_other(), 1'b1);
			end
		end

		cmd_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("affine_span_texture_mapper_tb: PASS");
		else
			$display("affine_span_texture_mapper_tb: FAIL");
		$finish;
	end

endmodule
